// ===== design/assert_macros.svh =====
// Assertion macros shared by the parser RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, clock, resetn, cond, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (cond) |-> (cons)) \
        else $error("same-cycle implication failed");

// Check that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(label, clock, resetn, cond, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) (cond) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/swfp_pkg.sv =====
// Types, codes and the known-tag lookup for the tag stream parser
`timescale 1ns / 1ps

package swfp_pkg;

    typedef enum logic [3:0] {
        PH_SIG     = 4'd0,
        PH_FIXED   = 4'd1,
        PH_RECT    = 4'd2,
        PH_PRE     = 4'd3,
        PH_TAG_LO  = 4'd4,
        PH_TAG_HI  = 4'd5,
        PH_LONG    = 4'd6,
        PH_PAYLOAD = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        EV_TAG   = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } event_t;

    localparam logic [7:0] SIG_F = 8'h46;
    localparam logic [7:0] SIG_W = 8'h57;
    localparam logic [7:0] SIG_S = 8'h53;

    localparam logic [31:0] FIXED_SKIP = 32'd5;
    localparam logic [31:0] PRE_SKIP   = 32'd3;
    localparam logic [7:0]  RECT_BIAS  = 8'd12;
    localparam logic [5:0]  LONG_FORM  = 6'h3f;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = SIG_F;
            2'd1:    r = SIG_W;
            default: r = SIG_S;
        endcase
        return r;
    endfunction

    function automatic logic is_known(input logic [9:0] code);
        logic r;
        case (code) inside
            10'd1, 10'd2, 10'd9, 10'd20, 10'd22, 10'd32, 10'd33, 10'd34,
            10'd36, 10'd37, 10'd39, 10'd43, 10'd56, 10'd65, 10'd69, 10'd73,
            10'd74, 10'd75, 10'd76, 10'd77, 10'd78, 10'd82, 10'd83, 10'd88:
                r = 1'b1;
            default:
                r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/swf_tag_stream_parser.sv =====
// Byte-serial SWF tag header parser with input and result registers
// A result is valid in the cycle after the parse stage processes its header's last beat.
// Throughput: one byte per cycle; the parse stage updates all state in one pass.
// Stalls from the result side hold the parse stage and back up to the input.
// Reset (rst_n low, asynchronous) clears both stages and returns the parser to
// the signature check at offset zero; start_of_file does the same per file.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swf_tag_stream_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [31:0] tag_offset,
    output logic [9:0]  tag_type,
    output logic [31:0] tag_length,
    output logic        known_type
);

    localparam int TW = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic                   s1_sof_reg;

    swfp_pkg::phase_t       phase_reg, phase_next, phase_cur;
    logic [1:0]             fc_reg, fc_next, fc_cur;
    logic [31:0]            skip_reg, skip_next, skip_cur;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next, offset_cur;
    logic [15:0]            hw_reg, hw_next, hw_cur;
    logic [31:0]            accum_reg, accum_next, accum_cur;
    logic [TW-1:0]          start_reg, start_next, start_cur;

    logic                   out_valid_reg;
    swfp_pkg::event_t       kind_reg, kind_next;
    logic [31:0]            toff_reg, toff_next;
    logic [9:0]             code_reg, code_next;
    logic [31:0]            len_reg, len_next;
    logic                   known_reg, known_next;
    logic                   emit;

    logic                   out_free;
    logic                   advance;
    logic [15:0]            hw_full;
    logic [9:0]             hdr_code;
    logic [5:0]             hdr_slen;
    logic [7:0]             rect_sum;
    logic [31:0]            accum_new;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;

    // hold the beat while the parse stage is blocked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_sof_reg  <= start_of_file;
        end
    end

    // restart from reset values at a file start
    always_comb
    begin
        if (s1_sof_reg)
        begin
            phase_cur  = swfp_pkg::PH_SIG;
            fc_cur     = '0;
            skip_cur   = '0;
            offset_cur = '0;
            hw_cur     = '0;
            accum_cur  = '0;
            start_cur  = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            fc_cur     = fc_reg;
            skip_cur   = skip_reg;
            offset_cur = offset_reg;
            hw_cur     = hw_reg;
            accum_cur  = accum_reg;
            start_cur  = start_reg;
        end
    end

    assign hw_full   = {s1_byte_reg, hw_cur[7:0]};
    assign hdr_code  = hw_full[15:6];
    assign hdr_slen  = hw_full[5:0];
    assign rect_sum  = swfp_pkg::RECT_BIAS + {1'b0, s1_byte_reg[7:3], 2'b00};
    assign accum_new = accum_cur | (32'(s1_byte_reg) << {fc_cur, 3'b000});

    always_comb
    begin
        phase_next  = phase_cur;
        fc_next     = fc_cur;
        skip_next   = skip_cur;
        offset_next = offset_cur + OFFSET_BITS'(1);
        hw_next     = hw_cur;
        accum_next  = accum_cur;
        start_next  = start_cur;

        unique case (phase_cur)
            swfp_pkg::PH_SIG:
            begin
                if (s1_byte_reg != swfp_pkg::sig_byte(fc_cur))
                begin
                    phase_next = swfp_pkg::PH_DONE;
                end
                else if (fc_cur == 2'd2)
                begin
                    fc_next    = '0;
                    skip_next  = swfp_pkg::FIXED_SKIP;
                    phase_next = swfp_pkg::PH_FIXED;
                end
                else
                begin
                    fc_next = fc_cur + 2'd1;
                end
            end
            swfp_pkg::PH_FIXED:
            begin
                skip_next = skip_cur - 32'd1;
                if (skip_cur == 32'd1)
                begin
                    phase_next = swfp_pkg::PH_RECT;
                end
            end
            swfp_pkg::PH_RECT:
            begin
                skip_next  = 32'(rect_sum[7:3]) + swfp_pkg::PRE_SKIP;
                phase_next = swfp_pkg::PH_PRE;
            end
            swfp_pkg::PH_PRE:
            begin
                skip_next = skip_cur - 32'd1;
                if (skip_cur == 32'd1)
                begin
                    phase_next = swfp_pkg::PH_TAG_LO;
                end
            end
            swfp_pkg::PH_TAG_LO:
            begin
                start_next = offset_cur[TW-1:0];
                hw_next    = {8'h00, s1_byte_reg};
                phase_next = swfp_pkg::PH_TAG_HI;
            end
            swfp_pkg::PH_TAG_HI:
            begin
                hw_next = hw_full;
                if (hdr_code == 10'd0)
                begin
                    phase_next = swfp_pkg::PH_DONE;
                end
                else if (hdr_slen == swfp_pkg::LONG_FORM)
                begin
                    accum_next = '0;
                    fc_next    = '0;
                    phase_next = swfp_pkg::PH_LONG;
                end
                else
                begin
                    skip_next  = 32'(hdr_slen);
                    phase_next = (hdr_slen == 6'd0) ? swfp_pkg::PH_TAG_LO
                                                    : swfp_pkg::PH_PAYLOAD;
                end
            end
            swfp_pkg::PH_LONG:
            begin
                accum_next = accum_new;
                if (fc_cur == 2'd3)
                begin
                    fc_next    = '0;
                    skip_next  = accum_new;
                    phase_next = (accum_new == 32'd0) ? swfp_pkg::PH_TAG_LO
                                                      : swfp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    fc_next = fc_cur + 2'd1;
                end
            end
            swfp_pkg::PH_PAYLOAD:
            begin
                skip_next = skip_cur - 32'd1;
                if (skip_cur == 32'd1)
                begin
                    phase_next = swfp_pkg::PH_TAG_LO;
                end
            end
            default:
            begin
                phase_next = swfp_pkg::PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        emit       = 1'b0;
        kind_next  = swfp_pkg::EV_TAG;
        toff_next  = 32'(start_cur);
        code_next  = '0;
        len_next   = '0;
        known_next = 1'b0;

        unique case (phase_cur)
            swfp_pkg::PH_SIG:
            begin
                if (s1_byte_reg != swfp_pkg::sig_byte(fc_cur))
                begin
                    emit      = 1'b1;
                    kind_next = swfp_pkg::EV_ERROR;
                    toff_next = 32'(offset_cur[TW-1:0]);
                end
            end
            swfp_pkg::PH_TAG_HI:
            begin
                if (hdr_code == 10'd0)
                begin
                    emit      = 1'b1;
                    kind_next = swfp_pkg::EV_END;
                    len_next  = 32'(hdr_slen);
                end
                else if (hdr_slen != swfp_pkg::LONG_FORM)
                begin
                    emit       = 1'b1;
                    code_next  = hdr_code;
                    len_next   = 32'(hdr_slen);
                    known_next = swfp_pkg::is_known(hdr_code);
                end
            end
            swfp_pkg::PH_LONG:
            begin
                if (fc_cur == 2'd3)
                begin
                    emit       = 1'b1;
                    code_next  = hw_cur[15:6];
                    len_next   = accum_new;
                    known_next = swfp_pkg::is_known(hw_cur[15:6]);
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // advance parser state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= swfp_pkg::PH_SIG;
            fc_reg     <= '0;
            skip_reg   <= '0;
            offset_reg <= '0;
            hw_reg     <= '0;
            accum_reg  <= '0;
            start_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            skip_reg   <= skip_next;
            offset_reg <= offset_next;
            hw_reg     <= hw_next;
            accum_reg  <= accum_next;
            start_reg  <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg  <= kind_next;
            toff_reg  <= toff_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            known_reg <= known_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = kind_reg;
    assign tag_offset = toff_reg;
    assign tag_type   = code_reg;
    assign tag_length = len_reg;
    assign known_type = known_reg;

    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall,
        s1_valid_reg && out_valid_reg && out_stall)
    `ASSERT_IMPLIES(a_known_only_tag, clk, rst_n,
        out_valid && (event_kind != swfp_pkg::EV_TAG), !known_type && (tag_type == 10'd0))
    `ASSERT_NEXT(a_done_silent, clk, rst_n,
        advance && (phase_reg == swfp_pkg::PH_DONE) && !s1_sof_reg && !out_valid_reg,
        !out_valid_reg)

endmodule
